// File: src/bsm_pkg.sv
package bsm_pkg;

  localparam int PATTERN_COUNT = 7;
  localparam int MAX_PATTERN_ELEMENTS = 16;
  localparam int POS_W = $clog2(MAX_PATTERN_ELEMENTS);
  localparam int LANE_IDX_W = $clog2(PATTERN_COUNT);

  // Format group codes written to the configuration register.
  localparam logic [1:0] FMT_WK   = 2'd0;
  localparam logic [1:0] FMT_WB   = 2'd1;
  localparam logic [1:0] FMT_SYLK = 2'd2;
  localparam logic [1:0] FMT_DIF  = 2'd3;

  typedef logic [LANE_IDX_W-1:0] lane_idx_t;
  typedef logic [POS_W-1:0] lane_pos_t;
  typedef logic [PATTERN_COUNT-1:0] lane_mask_t;

  typedef struct packed {
    logic alive;
    logic matched;
  } lane_status_t;

  function automatic lane_mask_t group_mask(logic [1:0] fmt);
    lane_mask_t m;
    unique case (fmt)
      FMT_WK:   m = 7'h07;
      FMT_WB:   m = 7'h08;
      FMT_SYLK: m = 7'h10;
      FMT_DIF:  m = 7'h60;
      default:  m = '0;
    endcase
    return m;
  endfunction

  function automatic lane_pos_t lane_len(lane_idx_t lane);
    lane_pos_t len;
    unique case (lane)
      3'd0:    len = 4'd6;
      3'd1:    len = 4'd9;
      3'd2:    len = 4'd8;
      3'd3:    len = 4'd6;
      3'd4:    len = 4'd4;
      3'd5:    len = 4'd13;
      3'd6:    len = 4'd11;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // True when element pos of the lane's signature takes byte b.
  function automatic logic lane_accepts(lane_idx_t lane, lane_pos_t pos, logic [7:0] b);
    logic ok;
    ok = 1'b0;
    unique case (lane)
      3'd0: begin
        unique case (pos)
          4'd0, 4'd1, 4'd3: ok = (b == 8'h00);
          4'd2:             ok = (b == 8'h02);
          4'd4:             ok = (b == 8'h04) || (b == 8'h06);
          4'd5:             ok = (b == 8'h04);
          default:          ok = 1'b0;
        endcase
      end
      3'd1: begin
        unique case (pos)
          4'd0, 4'd1, 4'd3, 4'd7, 4'd8: ok = (b == 8'h00);
          4'd2:    ok = 1'b1;
          4'd4:    ok = (b == 8'h03) || (b == 8'h04) || (b == 8'h05);
          4'd5:    ok = (b == 8'h10);
          4'd6:    ok = (b == 8'h04);
          default: ok = 1'b0;
        endcase
      end
      3'd2: begin
        unique case (pos)
          4'd0, 4'd1, 4'd3, 4'd7: ok = (b == 8'h00);
          4'd2:    ok = (b == 8'h1A);
          4'd4:    ok = (b == 8'h00) || (b == 8'h02);
          4'd5:    ok = (b == 8'h10);
          4'd6:    ok = (b == 8'h04);
          default: ok = 1'b0;
        endcase
      end
      3'd3: begin
        unique case (pos)
          4'd0, 4'd1, 4'd3: ok = (b == 8'h00);
          4'd2:    ok = (b == 8'h02);
          4'd4:    ok = (b == 8'h01) || (b == 8'h02) || (b == 8'h06) || (b == 8'h07);
          4'd5:    ok = (b == 8'h10);
          default: ok = 1'b0;
        endcase
      end
      3'd4: begin
        unique case (pos)
          4'd0:    ok = (b == 8'h49);
          4'd1:    ok = (b == 8'h44);
          4'd2:    ok = (b == 8'h3B);
          4'd3:    ok = (b == 8'h50) || (b == 8'h4E) || (b == 8'h45);
          default: ok = 1'b0;
        endcase
      end
      3'd5: begin
        unique case (pos)
          4'd0:    ok = (b == 8'h54);
          4'd1:    ok = (b == 8'h41);
          4'd2:    ok = (b == 8'h42);
          4'd3:    ok = (b == 8'h4C);
          4'd4:    ok = (b == 8'h45);
          4'd5, 4'd6, 4'd10, 4'd11: ok = 1'b1;
          4'd7:    ok = (b == 8'h30);
          4'd8:    ok = (b == 8'h2C);
          4'd9:    ok = (b == 8'h31);
          4'd12:   ok = (b == 8'h22);
          default: ok = 1'b0;
        endcase
      end
      3'd6: begin
        unique case (pos)
          4'd0:    ok = (b == 8'h54);
          4'd1:    ok = (b == 8'h41);
          4'd2:    ok = (b == 8'h42);
          4'd3:    ok = (b == 8'h4C);
          4'd4:    ok = (b == 8'h45);
          4'd5, 4'd9: ok = 1'b1;
          4'd6:    ok = (b == 8'h30);
          4'd7:    ok = (b == 8'h2C);
          4'd8:    ok = (b == 8'h31);
          4'd10:   ok = (b == 8'h22);
          default: ok = 1'b0;
        endcase
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// File: src/bsm_lane.sv
module bsm_lane
  import bsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lane_idx_t    lane_id,
  input  logic         advance,
  input  logic         restart,
  input  logic [7:0]   byte_value,
  output lane_status_t status_nxt
);

  lane_pos_t pos_r, pos_nxt;
  logic      alive_r, alive_nxt;
  logic      matched_r, matched_nxt;

  lane_pos_t pos_cur;
  logic      alive_cur;
  logic      matched_cur;

  always_comb begin
    // A restart takes effect before the current byte is examined.
    pos_cur     = restart ? '0 : pos_r;
    alive_cur   = restart ? 1'b1 : alive_r;
    matched_cur = restart ? 1'b0 : matched_r;

    pos_nxt     = pos_cur;
    alive_nxt   = alive_cur;
    matched_nxt = matched_cur;
    if (alive_cur && !matched_cur) begin
      priority if (pos_cur >= lane_len(lane_id)) begin
        matched_nxt = 1'b1;
      end else if (lane_accepts(lane_id, pos_cur, byte_value)) begin
        pos_nxt = pos_cur + POS_W'(1);
      end else begin
        alive_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      alive_r   <= 1'b1;
      matched_r <= 1'b0;
    end else if (advance) begin
      pos_r     <= pos_nxt;
      alive_r   <= alive_nxt;
      matched_r <= matched_nxt;
    end
  end

  assign status_nxt.alive   = alive_nxt;
  assign status_nxt.matched = matched_nxt;

endmodule

// File: src/byte_signature_matcher_unit.sv
// Tests the leading bytes of a file, one byte per transfer, against seven fixed
// signatures in parallel lanes and reports the hit mask plus detected/decided
// for the group picked by cfg_format_select. One byte is taken every cycle while
// no result is stalled; each result appears in the cycle after its byte, from an
// output register, and the per-lane element compare runs as the byte is taken.
// A byte is taken while the current result waits, as long as that result is
// transferred on the same edge. in_first_byte restarts all lanes.
module byte_signature_matcher_unit
  import bsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_format_select,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_detected,
  output logic       out_decided,
  output logic [6:0] out_pattern_hits
);

  logic [1:0]   format_select_r;
  logic         out_valid_r;
  logic         detected_r, detected_nxt;
  logic         decided_r, decided_nxt;
  lane_mask_t   hits_r, hits_nxt;
  lane_mask_t   alive_nxt;
  lane_mask_t   gm;
  lane_status_t lane_st [PATTERN_COUNT];
  logic         in_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < PATTERN_COUNT; i++) begin : g_lane
    bsm_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .lane_id    (LANE_IDX_W'(i)),
      .advance    (in_xfer),
      .restart    (in_first_byte),
      .byte_value (in_byte_value),
      .status_nxt (lane_st[i])
    );
    assign hits_nxt[i]  = lane_st[i].matched;
    assign alive_nxt[i] = lane_st[i].alive;
  end

  always_comb begin
    gm           = group_mask(format_select_r);
    detected_nxt = |(hits_nxt & gm);
    decided_nxt  = detected_nxt || !(|(alive_nxt & gm)) || in_last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_select_r <= FMT_WK;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        format_select_r <= cfg_format_select;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      detected_r <= detected_nxt;
      decided_r  <= decided_nxt;
      hits_r     <= hits_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_detected     = detected_r;
  assign out_decided      = decided_r;
  assign out_pattern_hits = hits_r;

endmodule

// File: src/bsm_checker.sv
module bsm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_first_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_detected,
  input logic       out_decided,
  input logic [6:0] out_pattern_hits
);

  // A match of the selected group always settles the decision.
  a_detected_decided: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_detected |-> out_decided)
    else $error("detected result without decided");

  a_detected_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_detected |-> out_pattern_hits != 7'd0)
    else $error("detected result with empty hit mask");

  // Every accepted byte yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

  // Without a restart, a lane that has matched stays matched.
  a_hits_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_first_byte && out_valid |=>
      (out_pattern_hits & $past(out_pattern_hits)) == $past(out_pattern_hits))
    else $error("pattern hit cleared without restart");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pattern_hits)
      && $stable(out_detected) && $stable(out_decided))
    else $error("stalled result changed");

endmodule

bind byte_signature_matcher_unit bsm_checker u_bsm_checker (.*);

// File: bench/byte_signature_matcher_unit_test.sv
`timescale 1ns / 100ps

module byte_signature_matcher_unit_test;
  import bsm_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int TAIL_CYCLES = 8;
  localparam int BYTE_TARGET = 1800;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam logic [2:0] ANY_BYTE = 3'd0;

  typedef struct packed {
    logic [2:0]      choices;
    logic [3:0][7:0] bytes;
  } sig_elem_t;

  typedef struct packed {
    logic       detected;
    logic       decided;
    lane_mask_t hits;
  } verdict_t;

  localparam lane_mask_t GROUP_LANES [4] = '{7'h07, 7'h08, 7'h10, 7'h60};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_format_select = FMT_WK;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte_value = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_detected;
  logic       out_decided;
  logic [6:0] out_pattern_hits;

  byte_signature_matcher_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_format_select(cfg_format_select),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte_value(in_byte_value),
    .in_first_byte(in_first_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_detected(out_detected),
    .out_decided(out_decided),
    .out_pattern_hits(out_pattern_hits)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Signature tables and the predicted lane state.
  sig_elem_t  signature [PATTERN_COUNT][MAX_PATTERN_ELEMENTS];
  int         sig_len [PATTERN_COUNT] = '{default: 0};
  lane_pos_t  lane_at [PATTERN_COUNT];
  lane_mask_t lane_live;
  lane_mask_t lane_done;
  logic [1:0] format_model;

  verdict_t   pending_verdicts [$];
  int         mismatch_count = 0;
  int         bytes_sent = 0;
  int         stuck_cycles = 0;
  int         hold_off_request = 0;
  bit         idle_on = 1'b1;
  bit         offering = 1'b0;
  longint     drop_stamp = -1;

  task automatic add_element(int lane, logic [2:0] n, logic [7:0] a, logic [7:0] b,
                             logic [7:0] c, logic [7:0] d);
    signature[lane][sig_len[lane]] = '{n, {d, c, b, a}};
    sig_len[lane]++;
  endtask

  task automatic exact(int lane, logic [7:0] v);
    add_element(lane, 3'd1, v, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic dont_care(int lane);
    add_element(lane, ANY_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic exact_text(int lane, string s);
    for (int k = 0; k < s.len(); k++) exact(lane, s[k]);
  endtask

  initial begin
    exact(0, 8'h00); exact(0, 8'h00); exact(0, 8'h02); exact(0, 8'h00);
    add_element(0, 3'd2, 8'h04, 8'h06, 8'h00, 8'h00); exact(0, 8'h04);

    exact(1, 8'h00); exact(1, 8'h00); dont_care(1); exact(1, 8'h00);
    add_element(1, 3'd3, 8'h03, 8'h04, 8'h05, 8'h00);
    exact(1, 8'h10); exact(1, 8'h04); exact(1, 8'h00); exact(1, 8'h00);

    exact(2, 8'h00); exact(2, 8'h00); exact(2, 8'h1A); exact(2, 8'h00);
    add_element(2, 3'd2, 8'h00, 8'h02, 8'h00, 8'h00);
    exact(2, 8'h10); exact(2, 8'h04); exact(2, 8'h00);

    exact(3, 8'h00); exact(3, 8'h00); exact(3, 8'h02); exact(3, 8'h00);
    add_element(3, 3'd4, 8'h01, 8'h02, 8'h06, 8'h07); exact(3, 8'h10);

    exact_text(4, "ID;");
    add_element(4, 3'd3, "P", "N", "E", 8'h00);

    exact_text(5, "TABLE"); dont_care(5); dont_care(5);
    exact_text(5, "0,1"); dont_care(5); dont_care(5); exact(5, "\"");

    exact_text(6, "TABLE"); dont_care(6);
    exact_text(6, "0,1"); dont_care(6); exact(6, "\"");
  end

  function automatic logic element_takes(sig_elem_t e, logic [7:0] v);
    if (e.choices == ANY_BYTE) return 1'b1;
    for (int k = 0; k < int'(e.choices); k++) begin
      if (e.bytes[k] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] sample_element(sig_elem_t e);
    if (e.choices == ANY_BYTE) return 8'($urandom);
    return e.bytes[$urandom_range(0, int'(e.choices) - 1)];
  endfunction

  function automatic void restart_lanes();
    for (int i = 0; i < PATTERN_COUNT; i++) lane_at[i] = '0;
    lane_live = '1;
    lane_done = '0;
  endfunction

  // Steps every lane by one byte and queues the verdict that byte produces.
  function automatic void advance_lanes(logic [7:0] v, logic first, logic last);
    lane_mask_t group;
    verdict_t   verdict;
    if (first) restart_lanes();
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      if (lane_live[i] && !lane_done[i]) begin
        if (int'(lane_at[i]) >= sig_len[i]) lane_done[i] = 1'b1;
        else if (element_takes(signature[i][lane_at[i]], v)) lane_at[i] = lane_at[i] + 1'b1;
        else lane_live[i] = 1'b0;
      end
    end
    group = GROUP_LANES[format_model];
    verdict.hits = lane_done;
    verdict.detected = |(lane_done & group);
    verdict.decided = verdict.detected || ((lane_live & group) == '0) || last;
    pending_verdicts.push_back(verdict);
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_byte(logic [7:0] v, logic first, logic last);
    int gap;
    gap = pick_gap();
    // Valid cannot be lowered and raised in the same step.
    if (!offering && drop_stamp == $time && gap == 0) gap = 1;
    if (gap > 0) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= v;
    in_first_byte <= first;
    in_last_byte <= last;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    advance_lanes(v, first, last);
  endtask

  task automatic stop_sending();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      drop_stamp = $time;
    end
  endtask

  task automatic drain_results();
    stop_sending();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_format(logic [1:0] fmt);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_format_select <= fmt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    format_model = fmt;
  endtask

  // Sends a stream that follows one lane's signature for its first bytes, bar break_at.
  task automatic send_stream(int lane, int total, int break_at, bit with_first, bit with_last);
    logic [7:0] v;
    for (int i = 0; i < total; i++) begin
      if (i < sig_len[lane]) v = sample_element(signature[lane][i]);
      else v = 8'($urandom);
      if (i == break_at) v = 8'($urandom);
      send_byte(v, with_first && i == 0, with_last && i == total - 1);
    end
  endtask

  task automatic test_start_without_first();
    logic [7:0] seq [9];
    seq = '{8'h00, 8'h00, 8'h1A, 8'h00, 8'h02, 8'h10, 8'h04, 8'h00, 8'hFF};
    for (int i = 0; i < 9; i++) send_byte(seq[i], 1'b0, i == 8);
  endtask

  task automatic test_match_then_ignore();
    logic [7:0] seq [6];
    write_format(FMT_SYLK);
    seq = '{8'h49, 8'h44, 8'h3B, 8'h45, 8'hFF, 8'h80};
    for (int i = 0; i < 6; i++) send_byte(seq[i], i == 0, i == 5);
  endtask

  task automatic test_dead_group_and_after_last();
    write_format(FMT_WB);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h05, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_off_request = HOLD_OFF_CYCLES;
    send_stream(6, sig_len[6] + 1, -1, 1'b1, 1'b0);
    send_stream(5, sig_len[5] + 1 + 4, -1, 1'b1, 1'b1);
    // The sender now waits for every outstanding result.
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int phase;
    int lane;
    int total;
    int kind;
    int cut;
    logic [1:0] fmt;
    phase = 0;
    while (bytes_sent < BYTE_TARGET) begin
      case (phase)
        0:       fmt = FMT_WK;
        1:       fmt = FMT_DIF;
        2:       fmt = FMT_WB;
        3:       fmt = FMT_SYLK;
        default: fmt = 2'($urandom);
      endcase
      write_format(fmt);
      idle_on = (phase % 3 != 2);
      repeat (20) begin
        lane = $urandom_range(0, PATTERN_COUNT - 1);
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          total = sig_len[lane] + 1 + $urandom_range(0, 4);
          cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : -1;
          send_stream(lane, total, cut, 1'b1, $urandom_range(0, 7) != 0);
        end else if (kind < 80) begin
          send_stream(lane, $urandom_range(1, sig_len[lane]), -1, 1'b1, 1'b1);
        end else if (kind < 90) begin
          repeat ($urandom_range(1, 12))
            send_byte(8'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          send_stream(lane, sig_len[lane] + 1, -1, 1'b0, 1'($urandom));
        end
      end
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        stall = hold_off_request;
        hold_off_request = 0;
      end else if (stall == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, hits", out_pattern_hits, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_detected !== want.detected)
          report_mismatch("detected", out_detected, want.detected);
        if (out_decided !== want.decided)
          report_mismatch("decided", out_decided, want.decided);
        if (out_pattern_hits !== want.hits)
          report_mismatch("pattern_hits", out_pattern_hits, want.hits);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    format_model = FMT_WK;
    restart_lanes();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_start_without_first();
    test_match_then_ignore();
    test_dead_group_and_after_last();
    test_backpressure();
    test_random_streams();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
